### rtl/mm3_pkg.sv
// Package for the byte-serial MurmurHash3 x86_32 hasher.
// Holds mixing constants, register indexes, the sequencer state and multiplier op types.
// No dependencies.
`default_nettype none

package mm3_pkg;

    localparam int unsigned HASH_W    = 32;
    localparam int unsigned CFG_IDX_W = 8;

    localparam logic [HASH_W-1:0] MIX_C1     = 32'hcc9e2d51;
    localparam logic [HASH_W-1:0] MIX_C2     = 32'h1b873593;
    localparam logic [HASH_W-1:0] STEP_ADD   = 32'he6546b64;
    localparam logic [HASH_W-1:0] FIN_M1     = 32'h85ebca6b;
    localparam logic [HASH_W-1:0] FIN_M2     = 32'hc2b2ae35;
    localparam logic [HASH_W-1:0] SEED_RESET = 32'h05d9ee90;

    localparam logic [CFG_IDX_W-1:0] CFG_HASH_SEED      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_TOP_BITS = 8'd1;

    typedef enum logic [1:0] {
        MOP_C1,
        MOP_C2,
        MOP_FM1,
        MOP_FM2
    } mul_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MIX_C1,
        S_MIX_C2,
        S_MIX_H,
        S_FIN_PREP,
        S_TAIL_C1,
        S_TAIL_C2,
        S_FIN_M1,
        S_FIN_M2,
        S_FIN_OUT
    } seq_state_t;

endpackage

`default_nettype wire

### rtl/mm3_mul_unit.sv
// Shared multiply unit: operand pre-mix (none, rotate or xor-shift) and a 32-bit
// multiply by a selected constant, low word kept.
// Depends on mm3_pkg.
`default_nettype none

module mm3_mul_unit
    import mm3_pkg::*;
(
    input  wire mul_op_t           op,
    input  wire logic [HASH_W-1:0] operand,
    output logic      [HASH_W-1:0] product
);

    logic [HASH_W-1:0]   pre;
    logic [HASH_W-1:0]   factor;
    logic [2*HASH_W-1:0] full;

    always_comb
    begin
        unique case (op)
            MOP_C1:
            begin
                pre    = operand;
                factor = MIX_C1;
            end
            MOP_C2:
            begin
                pre    = {operand[HASH_W-16:0], operand[HASH_W-1:HASH_W-15]};
                factor = MIX_C2;
            end
            MOP_FM1:
            begin
                pre    = operand ^ (operand >> 16);
                factor = FIN_M1;
            end
            MOP_FM2:
            begin
                pre    = operand ^ (operand >> 13);
                factor = FIN_M2;
            end
            default:
            begin
                pre    = operand;
                factor = MIX_C1;
            end
        endcase
    end

    assign full    = {{HASH_W{1'b0}}, pre} * {{HASH_W{1'b0}}, factor};
    assign product = full[HASH_W-1:0];

endmodule

`default_nettype wire

### rtl/murmur3_32_byte_hasher.sv
// MurmurHash3 x86_32 over a byte stream, one message byte per input transfer.
// A byte that does not complete a 32-bit word is buffered. A byte that
// completes a word passes accept, two scramble multiplies and the hash
// step. The end-of-message transfer then passes a prepare step, two tail
// multiplies when tail bytes remain, two finalizer multiplies and an output
// step; the output stage stalls there only while a previous hash still waits.
// All multiplies go through one shared 32x32 multiplier.
// Configuration writes are accepted only while the sequencer is idle and take
// the cycle ahead of an input transfer offered at the same time.
// Depends on mm3_pkg and mm3_mul_unit.
`default_nettype none

module murmur3_32_byte_hasher
    import mm3_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [HASH_W-1:0]    cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [7:0]           data_byte,
    input  wire logic                 has_byte,
    input  wire logic                 last_item,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic      [HASH_W-1:0]    hash_value
);

    seq_state_t        state_reg, state_next;
    logic [HASH_W-1:0] seed_reg, seed_next;
    logic              clear_reg, clear_next;
    logic [HASH_W-1:0] hash_reg, hash_next;
    logic [23:0]       pend_reg, pend_next;
    logic [HASH_W-1:0] len_reg, len_next;
    logic [HASH_W-1:0] k_reg, k_next;
    logic [HASH_W-1:0] fin_reg, fin_next;
    logic              last_reg, last_next;
    logic [HASH_W-1:0] out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    mul_op_t           mul_op;
    logic [HASH_W-1:0] mul_in;
    logic [HASH_W-1:0] mul_out;
    logic [HASH_W-1:0] mix_x;
    logic [HASH_W-1:0] mix_r;
    logic [HASH_W-1:0] fin_x;
    logic [1:0]        slot;
    logic              in_xfer;
    logic              cfg_xfer;

    mm3_mul_unit u_mul (
        .op      (mul_op),
        .operand (mul_in),
        .product (mul_out)
    );

    assign in_ready   = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready  = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign hash_value = out_reg;
    assign in_xfer    = in_valid && in_ready;
    assign cfg_xfer   = cfg_valid && cfg_ready;
    assign slot       = len_reg[1:0];

    assign mix_x = hash_reg ^ k_reg;
    assign mix_r = {mix_x[HASH_W-14:0], mix_x[HASH_W-1:HASH_W-13]};
    assign fin_x = fin_reg ^ (fin_reg >> 16);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seed_reg      <= SEED_RESET;
            clear_reg     <= 1'b0;
            hash_reg      <= SEED_RESET;
            pend_reg      <= '0;
            len_reg       <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seed_reg      <= seed_next;
            clear_reg     <= clear_next;
            hash_reg      <= hash_next;
            pend_reg      <= pend_next;
            len_reg       <= len_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg   <= k_next;
        fin_reg <= fin_next;
        out_reg <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        seed_next      = seed_reg;
        clear_next     = clear_reg;
        hash_next      = hash_reg;
        pend_next      = pend_reg;
        len_next       = len_reg;
        k_next         = k_reg;
        fin_next       = fin_reg;
        last_next      = last_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mul_op         = MOP_C1;
        mul_in         = k_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    last_next = last_item;
                    if (has_byte)
                    begin
                        len_next = len_reg + 1'b1;
                    end
                    if (has_byte && slot == 2'd3)
                    begin
                        k_next     = {data_byte, pend_reg};
                        pend_next  = '0;
                        state_next = S_MIX_C1;
                    end
                    else
                    begin
                        if (has_byte)
                        begin
                            unique case (slot)
                                2'd0:    pend_next[7:0]   = data_byte;
                                2'd1:    pend_next[15:8]  = data_byte;
                                2'd2:    pend_next[23:16] = data_byte;
                                default: pend_next        = pend_reg;
                            endcase
                        end
                        if (last_item)
                        begin
                            state_next = S_FIN_PREP;
                        end
                    end
                end
            end
            S_MIX_C1:
            begin
                mul_op     = MOP_C1;
                k_next     = mul_out;
                state_next = S_MIX_C2;
            end
            S_MIX_C2:
            begin
                mul_op     = MOP_C2;
                k_next     = mul_out;
                state_next = S_MIX_H;
            end
            S_MIX_H:
            begin
                hash_next  = {mix_r[HASH_W-3:0], 2'b00} + mix_r + STEP_ADD;
                state_next = last_reg ? S_FIN_PREP : S_IDLE;
            end
            S_FIN_PREP:
            begin
                fin_next   = hash_reg ^ len_reg;
                k_next     = {8'h00, pend_reg};
                state_next = (slot != 2'd0) ? S_TAIL_C1 : S_FIN_M1;
            end
            S_TAIL_C1:
            begin
                mul_op     = MOP_C1;
                k_next     = mul_out;
                state_next = S_TAIL_C2;
            end
            S_TAIL_C2:
            begin
                mul_op     = MOP_C2;
                fin_next   = fin_reg ^ mul_out;
                state_next = S_FIN_M1;
            end
            S_FIN_M1:
            begin
                mul_op     = MOP_FM1;
                mul_in     = fin_reg;
                fin_next   = mul_out;
                state_next = S_FIN_M2;
            end
            S_FIN_M2:
            begin
                mul_op     = MOP_FM2;
                mul_in     = fin_reg;
                fin_next   = mul_out;
                state_next = S_FIN_OUT;
            end
            S_FIN_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = clear_reg ? {2'b00, fin_x[HASH_W-3:0]} : fin_x;
                    out_valid_next = 1'b1;
                    hash_next      = seed_reg;
                    pend_next      = '0;
                    len_next       = '0;
                    last_next      = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_xfer)
        begin
            if (cfg_index == CFG_HASH_SEED)
            begin
                seed_next = cfg_data;
                if (len_reg == '0)
                begin
                    hash_next = cfg_data;
                end
            end
            else if (cfg_index == CFG_CLEAR_TOP_BITS)
            begin
                clear_next = cfg_data[0];
            end
        end
    end

endmodule

`default_nettype wire
